// File: hdl/ghsp_pkg.sv
// Shared package for the geometric history sum predictor.
// Holds default sizes, the queued item type, back-end control and state codes.
// No dependencies.
package ghsp_pkg;

	localparam int NUM_TABLES_DEF      = 5;
	localparam int INDEX_BITS_DEF      = 10;
	localparam int COUNTER_BITS_DEF    = 6;
	localparam int THRESH_CTR_BITS_DEF = 7;
	localparam int HISTORY_BITS_DEF    = 32;

	localparam int PC_W     = 32;
	localparam int CONF_W   = 10;
	localparam int THRESH_W = 8;
	localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd5;
	localparam logic [THRESH_W-1:0] THRESH_MAX   = 8'd255;

	typedef enum logic {
		REQ_PREDICT = 1'b0,
		REQ_UPDATE  = 1'b1
	} req_t;

	typedef struct packed {
		req_t             req;
		logic [PC_W-1:0]  pc;
		logic             res;
		logic             pred;
		logic             wrong;
	} item_t;

	typedef struct packed {
		logic pop;
		logic busy;
	} back_ctl_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

// File: hdl/geometric_history_sum_predictor_top.sv
// Top level of the geometric history sum branch direction predictor.
// Depends on ghsp_pkg, ghsp_front, ghsp_back (which uses ghsp_table).
//
// Usage:
//   Input side is a queue: drive req_type, branch_pc, resolved_taken and
//   predicted_taken with push; the item is taken on an edge where full is low.
//   A predict item (req_type 0) sums the centred counters of all tables and
//   returns prediction plus confidence_sum. An update item (req_type 1)
//   trains the counters when mispredicted or low-confidence, adapts the
//   threshold and shifts the outcome into the global history.
//   Result side is a queue: while empty is low the oldest result sits on
//   prediction, confidence_sum and threshold_now; pop takes it.
// Timing:
//   Each item passes the back end in order: a read of the tables at the folded
//   index, then a sum or a write-back of the trained counters. A new item is
//   taken only after the last one has left the execute state; empty falls once
//   the item has passed the input queue, the table read and the execute state.
// Reset:
//   arst_n clears control state, then a clearing pass walks all 2^INDEX_BITS
//   addresses (1024 by default), writes the midpoint into every counter, with full held high.
// Stall:
//   If pop is held low, the result holds, the back end waits, and the
//   two-entry input queue fills up until full rises.
module geometric_history_sum_predictor_top #(
	parameter int NUM_TABLES      = ghsp_pkg::NUM_TABLES_DEF,
	parameter int INDEX_BITS      = ghsp_pkg::INDEX_BITS_DEF,
	parameter int COUNTER_BITS    = ghsp_pkg::COUNTER_BITS_DEF,
	parameter int THRESH_CTR_BITS = ghsp_pkg::THRESH_CTR_BITS_DEF,
	parameter int HISTORY_BITS    = ghsp_pkg::HISTORY_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic                               req_type,
	input  logic [ghsp_pkg::PC_W-1:0]          branch_pc,
	input  logic                               resolved_taken,
	input  logic                               predicted_taken,
	output logic                               empty,
	input  logic                               pop,
	output logic                               prediction,
	output logic signed [ghsp_pkg::CONF_W-1:0] confidence_sum,
	output logic [ghsp_pkg::THRESH_W-1:0]      threshold_now
);

	ghsp_pkg::back_ctl_t ctl;
	ghsp_pkg::item_t     head;
	logic                head_valid;

	// Accept and queue items.
	ghsp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.req_type        (req_type),
		.branch_pc       (branch_pc),
		.resolved_taken  (resolved_taken),
		.predicted_taken (predicted_taken),
		.ctl             (ctl),
		.head_valid      (head_valid),
		.head            (head)
	);

	// Look up, train and hold the result.
	ghsp_back #(
		.NUM_TABLES      (NUM_TABLES),
		.INDEX_BITS      (INDEX_BITS),
		.COUNTER_BITS    (COUNTER_BITS),
		.THRESH_CTR_BITS (THRESH_CTR_BITS),
		.HISTORY_BITS    (HISTORY_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head           (head),
		.ctl            (ctl),
		.empty          (empty),
		.pop            (pop),
		.prediction     (prediction),
		.confidence_sum (confidence_sum),
		.threshold_now  (threshold_now)
	);

endmodule

// File: hdl/ghsp_table.sv
// One counter table: simple dual-port memory with registered read.
// Depends on nothing.
module ghsp_table #(
	parameter int AW = 10,
	parameter int DW = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// Hold the read word until the next lookup.
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hdl/ghsp_front.sv
// Front end: classifies incoming items and holds them in a two-entry queue.
// Depends on ghsp_pkg.
module ghsp_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic                       req_type,
	input  logic [ghsp_pkg::PC_W-1:0]  branch_pc,
	input  logic                       resolved_taken,
	input  logic                       predicted_taken,
	input  ghsp_pkg::back_ctl_t        ctl,
	output logic                       head_valid,
	output ghsp_pkg::item_t            head
);

	ghsp_pkg::item_t ent_q [2];
	logic            rd_q, wr_q;
	logic [1:0]      cnt_q;
	logic            do_push, do_pop;
	ghsp_pkg::item_t in_item;

	assign full       = (cnt_q == 2'd2) || ctl.busy;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = ctl.pop && head_valid;

	always_comb begin
		in_item.req   = ghsp_pkg::req_t'(req_type);
		in_item.pc    = branch_pc;
		in_item.res   = resolved_taken;
		in_item.pred  = predicted_taken;
		in_item.wrong = req_type && (resolved_taken != predicted_taken);
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// File: hdl/ghsp_back.sv
// Back end: table lookup, sum, training, threshold adaptation, history, result.
// Depends on ghsp_pkg and ghsp_table.
module ghsp_back #(
	parameter int NUM_TABLES      = ghsp_pkg::NUM_TABLES_DEF,
	parameter int INDEX_BITS      = ghsp_pkg::INDEX_BITS_DEF,
	parameter int COUNTER_BITS    = ghsp_pkg::COUNTER_BITS_DEF,
	parameter int THRESH_CTR_BITS = ghsp_pkg::THRESH_CTR_BITS_DEF,
	parameter int HISTORY_BITS    = ghsp_pkg::HISTORY_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 head_valid,
	input  ghsp_pkg::item_t                      head,
	output ghsp_pkg::back_ctl_t                  ctl,
	output logic                                 empty,
	input  logic                                 pop,
	output logic                                 prediction,
	output logic signed [ghsp_pkg::CONF_W-1:0]   confidence_sum,
	output logic [ghsp_pkg::THRESH_W-1:0]        threshold_now
);

	localparam int SUM_W = (COUNTER_BITS + 5 > ghsp_pkg::CONF_W) ?
		COUNTER_BITS + 5 : ghsp_pkg::CONF_W;
	localparam logic [COUNTER_BITS-1:0] CTR_MAX = {COUNTER_BITS{1'b1}};
	localparam logic [COUNTER_BITS-1:0] CTR_MID = COUNTER_BITS'(1) << (COUNTER_BITS - 1);
	localparam logic [THRESH_CTR_BITS-1:0] TCTR_MAX = {THRESH_CTR_BITS{1'b1}};
	localparam logic [THRESH_CTR_BITS-1:0] TCTR_MID =
		THRESH_CTR_BITS'(1) << (THRESH_CTR_BITS - 1);

	ghsp_pkg::state_t state_q, state_d;

	logic [HISTORY_BITS-1:0]       hist_q;
	logic signed [SUM_W-1:0]       last_sum_q;
	logic [ghsp_pkg::THRESH_W-1:0] thr_q;
	logic [THRESH_CTR_BITS-1:0]    tctr_q;
	logic [INDEX_BITS-1:0]         clr_q;
	ghsp_pkg::item_t               item_s1;
	logic [INDEX_BITS-1:0]         idx_s1 [NUM_TABLES];
	logic [INDEX_BITS-1:0]         idx_c  [NUM_TABLES];
	logic [COUNTER_BITS-1:0]       rdata  [NUM_TABLES];
	logic [COUNTER_BITS-1:0]       wdata  [NUM_TABLES];

	logic                          out_valid_q, pred_q;
	logic signed [ghsp_pkg::CONF_W-1:0] conf_q;
	logic [ghsp_pkg::THRESH_W-1:0] thr_out_q;

	logic                          take, fire, we_upd, low, is_upd;
	logic signed [SUM_W-1:0]       sum_c;
	logic [SUM_W-1:0]              mag_c;
	logic [ghsp_pkg::THRESH_W-1:0] thr_d;
	logic [THRESH_CTR_BITS-1:0]    tctr_d;

	// Folded index of one table.
	function automatic logic [INDEX_BITS-1:0] tbl_index(
		input logic [ghsp_pkg::PC_W-1:0] pc,
		input logic [HISTORY_BITS-1:0]   h,
		input int                        len
	);
		logic [INDEX_BITS-1:0] r;
		logic [INDEX_BITS-1:0] f1;
		logic [INDEX_BITS-1:0] f2;
		r  = '0;
		f1 = '0;
		f2 = '0;
		for (int b = 0; b < ghsp_pkg::PC_W; b++) begin
			r[b % INDEX_BITS] = r[b % INDEX_BITS] ^ pc[b];
		end
		for (int b = 0; b < HISTORY_BITS; b++) begin
			if (b < len) begin
				f1[b % INDEX_BITS] = f1[b % INDEX_BITS] ^ h[b];
				f2[b % (INDEX_BITS - 1)] = f2[b % (INDEX_BITS - 1)] ^ h[b];
			end
		end
		return r ^ f1 ^ {f2[INDEX_BITS-2:0], 1'b0};
	endfunction

	for (genvar t = 0; t < NUM_TABLES; t++) begin : g_tbl
		localparam int LEN = ((2 << t) > HISTORY_BITS) ? HISTORY_BITS : (2 << t);

		assign idx_c[t] = tbl_index(head.pc, hist_q, LEN);
		assign wdata[t] = (state_q == ghsp_pkg::ST_CLEAR) ? CTR_MID :
			item_s1.res ? ((rdata[t] != CTR_MAX) ? rdata[t] + 1'b1 : rdata[t]) :
			((rdata[t] != '0) ? rdata[t] - 1'b1 : rdata[t]);

		ghsp_table #(.AW(INDEX_BITS), .DW(COUNTER_BITS)) u_tbl (
			.clk   (clk),
			.we    ((state_q == ghsp_pkg::ST_CLEAR) || we_upd),
			.waddr ((state_q == ghsp_pkg::ST_CLEAR) ? clr_q : idx_s1[t]),
			.wdata (wdata[t]),
			.re    (take),
			.raddr (idx_c[t]),
			.rdata (rdata[t])
		);

		always_ff @(posedge clk) begin
			if (take) begin
				idx_s1[t] <= idx_c[t];
			end
		end
	end

	// Sum of centred counters: 2c+1 - 2*mid per table.
	always_comb begin
		sum_c = '0;
		for (int t = 0; t < NUM_TABLES; t++) begin
			sum_c = sum_c + $signed(SUM_W'({rdata[t], 1'b1}))
				- $signed(SUM_W'({CTR_MID, 1'b0}));
		end
	end

	assign is_upd = (item_s1.req == ghsp_pkg::REQ_UPDATE);
	assign mag_c  = last_sum_q[SUM_W-1] ? SUM_W'(-last_sum_q) : SUM_W'(last_sum_q);
	assign low    = mag_c < SUM_W'(thr_q);
	assign fire   = (state_q == ghsp_pkg::ST_EXEC) && (!out_valid_q || pop);
	assign take   = (state_q == ghsp_pkg::ST_IDLE) && head_valid;
	assign we_upd = fire && is_upd && (item_s1.wrong || low);

	// Threshold adaptation.
	always_comb begin
		thr_d  = thr_q;
		tctr_d = tctr_q;
		if (is_upd) begin
			if (item_s1.wrong) begin
				if (tctr_q != TCTR_MAX) begin
					tctr_d = tctr_q + 1'b1;
				end
				if (tctr_d == TCTR_MAX) begin
					if (thr_q != ghsp_pkg::THRESH_MAX) begin
						thr_d = thr_q + 1'b1;
					end
					tctr_d = TCTR_MID;
				end
			end else if (low) begin
				if (tctr_q != '0) begin
					tctr_d = tctr_q - 1'b1;
				end
				if (tctr_d == '0) begin
					if (thr_q != '0) begin
						thr_d = thr_q - 1'b1;
					end
					tctr_d = TCTR_MID;
				end
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ghsp_pkg::ST_CLEAR: begin
				if (clr_q == {INDEX_BITS{1'b1}}) begin
					state_d = ghsp_pkg::ST_IDLE;
				end
			end
			ghsp_pkg::ST_IDLE: begin
				if (take) begin
					state_d = ghsp_pkg::ST_EXEC;
				end
			end
			ghsp_pkg::ST_EXEC: begin
				if (fire) begin
					state_d = ghsp_pkg::ST_IDLE;
				end
			end
			default: state_d = ghsp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.pop  = take;
		ctl.busy = (state_q == ghsp_pkg::ST_CLEAR);
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= head;
		end
		if (fire) begin
			pred_q    <= !is_upd && !sum_c[SUM_W-1];
			conf_q    <= is_upd ? last_sum_q[ghsp_pkg::CONF_W-1:0]
				: sum_c[ghsp_pkg::CONF_W-1:0];
			thr_out_q <= thr_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ghsp_pkg::ST_CLEAR;
			clr_q       <= '0;
			hist_q      <= '0;
			last_sum_q  <= '0;
			thr_q       <= ghsp_pkg::THRESH_RESET;
			tctr_q      <= TCTR_MID;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ghsp_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
				if (is_upd) begin
					thr_q  <= thr_d;
					tctr_q <= tctr_d;
					hist_q <= {hist_q[HISTORY_BITS-2:0], item_s1.res};
				end else begin
					last_sum_q <= sum_c;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty          = !out_valid_q;
	assign prediction     = pred_q;
	assign confidence_sum = conf_q;
	assign threshold_now  = thr_out_q;

endmodule
